>>> hdl/dtw_pkg.sv
// Shared types, event codes and register indexes for the double-tap wake detector.
// No dependencies; imported by dtw_core and double_tap_wake_detector_unit.
package dtw_pkg;

  // Default on-screen limits, inclusive
  localparam int unsigned XLimitDefault = 1599;
  localparam int unsigned YLimitDefault = 2559;

  // Register reset values
  localparam logic [11:0] FeatherReset = 12'd150;
  localparam logic [15:0] WindowReset  = 16'd50;

  // Event kinds
  localparam logic [2:0] MODE_SLOT     = 3'd0;
  localparam logic [2:0] MODE_TRACK_ID = 3'd1;
  localparam logic [2:0] MODE_BUTTON   = 3'd2;
  localparam logic [2:0] MODE_X        = 3'd3;
  localparam logic [2:0] MODE_Y        = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_FEATHER  = 2'd1;
  localparam logic [1:0] CFG_WINDOW   = 2'd2;

  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic        enable;
    logic [11:0] feather_distance;
    logic [15:0] time_window;
  } dtw_cfg_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] event_value;
    logic [31:0]        now_ticks;
    logic               screen_on;
    logic               prox_covered;
  } dtw_item_t;

  typedef struct packed {
    logic        finger_down;
    logic        x_captured;
    logic        y_captured;
    logic        release_armed;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic        tap_count;
    logic [15:0] prev_x;
    logic [15:0] prev_y;
    logic [31:0] prev_time;
  } dtw_state_t;

  localparam dtw_state_t StateReset = '{
    finger_down:   1'b0,
    x_captured:    1'b0,
    y_captured:    1'b0,
    release_armed: 1'b1,
    cur_x:         16'd0,
    cur_y:         16'd0,
    tap_count:     1'b0,
    prev_x:        16'd0,
    prev_y:        16'd0,
    prev_time:     32'd0
  };

  // Drop the stored tap and the current point and disarm release; capture flags are kept
  function automatic dtw_state_t clear_taps(input dtw_state_t s);
    dtw_state_t r;
    r               = s;
    r.tap_count     = 1'b0;
    r.prev_time     = 32'd0;
    r.prev_x        = 16'd0;
    r.prev_y        = 16'd0;
    r.cur_x         = 16'd0;
    r.cur_y         = 16'd0;
    r.release_armed = 1'b0;
    return r;
  endfunction

endpackage

>>> hdl/dtw_core.sv
// Next-state and wake logic for one touch event of the double-tap wake detector.
// Purely combinational; depends on dtw_pkg.
module dtw_core
  import dtw_pkg::*;
#(
  parameter int unsigned X_LIMIT = XLimitDefault,
  parameter int unsigned Y_LIMIT = YLimitDefault
) (
  input  dtw_cfg_t   cfg,
  input  dtw_item_t  item,
  input  dtw_state_t state,
  output dtw_state_t state_nxt,
  output logic       wake
);

  localparam logic signed [15:0] XMax = 16'(X_LIMIT);
  localparam logic signed [15:0] YMax = 16'(Y_LIMIT);

  logic              is_release;
  logic              take_x;
  logic              take_y;
  logic [15:0]       tap_x;
  logic [15:0]       tap_y;
  logic              on_screen;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [16:0]       adx;
  logic [16:0]       ady;
  logic [31:0]       dt;
  logic              near;

  assign is_release = (item.mode == MODE_TRACK_ID) && (item.event_value == -16'sd1);
  assign take_x = (item.mode == MODE_X) && state.finger_down && !state.x_captured;
  assign take_y = (item.mode == MODE_Y) && state.finger_down && !state.y_captured;
  assign tap_x  = take_x ? item.event_value : state.cur_x;
  assign tap_y  = take_y ? item.event_value : state.cur_y;

  assign on_screen = ($signed(tap_x) >= 16'sd0) && ($signed(tap_x) <= XMax) &&
                     ($signed(tap_y) >= 16'sd0) && ($signed(tap_y) <= YMax);

  // 17-bit signed differences cannot overflow
  assign dx  = $signed({tap_x[15], tap_x}) - $signed({state.prev_x[15], state.prev_x});
  assign dy  = $signed({tap_y[15], tap_y}) - $signed({state.prev_y[15], state.prev_y});
  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);
  assign dt  = item.now_ticks - state.prev_time;   // wraps modulo 2^32

  assign near = (adx < {5'd0, cfg.feather_distance}) &&
                (ady < {5'd0, cfg.feather_distance}) &&
                (dt < {16'd0, cfg.time_window});

  always_comb begin
    state_nxt = state;
    wake      = 1'b0;
    if (!item.screen_on && cfg.enable) begin
      if ((item.mode == MODE_SLOT) && (item.event_value > 16'sd0)) begin
        // second finger
        if (state.finger_down) begin
          state_nxt = clear_taps(state);
        end
      end else if (!(is_release && !(state.x_captured && state.y_captured))) begin
        if (is_release) begin
          state_nxt.release_armed = 1'b1;
        end
        if ((item.mode == MODE_BUTTON) && (item.event_value == 16'sd1)) begin
          state_nxt.finger_down = 1'b1;
        end
        if ((item.mode == MODE_BUTTON) && (item.event_value == 16'sd0)) begin
          state_nxt.finger_down = 1'b0;
        end
        if (take_x) begin
          state_nxt.cur_x      = tap_x;
          state_nxt.x_captured = 1'b1;
        end
        if (take_y) begin
          state_nxt.cur_y      = tap_y;
          state_nxt.y_captured = 1'b1;
        end
        if (state_nxt.x_captured && state_nxt.y_captured &&
            state_nxt.release_armed && !state_nxt.finger_down) begin
          state_nxt.release_armed = 1'b0;
          state_nxt.x_captured    = 1'b0;
          state_nxt.y_captured    = 1'b0;
          if (!item.prox_covered && on_screen) begin
            if (!state.tap_count) begin
              state_nxt.prev_time = item.now_ticks;
              state_nxt.prev_x    = tap_x;
              state_nxt.prev_y    = tap_y;
              state_nxt.tap_count = 1'b1;
            end else if (near) begin
              state_nxt = clear_taps(state_nxt);
              wake      = 1'b1;
            end else begin
              state_nxt           = clear_taps(state_nxt);
              state_nxt.prev_time = item.now_ticks;
              state_nxt.prev_x    = tap_x;
              state_nxt.prev_y    = tap_y;
              state_nxt.tap_count = 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

>>> hdl/double_tap_wake_detector_unit.sv
// Double-tap wake detector: top level with channel registers and detector state.
// Depends on dtw_pkg and dtw_core.
//
// Usage
//   Input channel (in_*): one touch-controller event per transaction: event
//   kind, value, tick count, screen-on and proximity levels.
//   Result channel (out_*): exactly one transaction per input event, in order,
//   carrying the wake pulse and whether a first tap is held afterwards.
//   Config port (cfg_*): write-only; index 0 enable, 1 feather distance,
//   2 time window. Write only while no event is in flight.
// Timing
//   The event is registered at the accepting edge; when the result register
//   is free, the detector state and the result register are then updated
//   together and out_valid rises. Throughput is one event per cycle while the
//   result is not stalled; the state update (a 32-bit tick
//   subtract/compare beside two 17-bit distance compares) is the only loop.
// Stall
//   A stalled result holds; the input register keeps one event and in_stall
//   rises only while that register is full and the result cannot move.
// Reset
//   Synchronous, active low: channels empty, detection disabled, feather
//   distance 150, time window 50, no tap stored, release armed.
module double_tap_wake_detector_unit
  import dtw_pkg::*;
#(
  parameter int unsigned X_LIMIT = XLimitDefault,
  parameter int unsigned Y_LIMIT = YLimitDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_mode,
  input  logic signed [15:0]  in_event_value,
  input  logic [31:0]         in_now_ticks,
  input  logic                in_screen_on,
  input  logic                in_prox_covered,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_wake,
  output logic                out_first_tap_held
);

  dtw_cfg_t   cfg_r;
  dtw_item_t  item_r;
  logic       item_valid_r;
  dtw_state_t state_r;
  dtw_state_t state_nxt;
  logic       wake_nxt;
  logic       out_valid_r;
  logic       out_wake_r;
  logic       out_held_r;
  logic       advance;
  logic       in_take;
  logic       process;

  // result register free this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign process  = item_valid_r && advance;
  assign in_stall = item_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable           <= 1'b0;
      cfg_r.feather_distance <= FeatherReset;
      cfg_r.time_window      <= WindowReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:  cfg_r.enable           <= cfg_wdata[0];
        CFG_FEATHER: cfg_r.feather_distance <= cfg_wdata[11:0];
        CFG_WINDOW:  cfg_r.time_window      <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.mode         <= in_mode;
      item_r.event_value  <= in_event_value;
      item_r.now_ticks    <= in_now_ticks;
      item_r.screen_on    <= in_screen_on;
      item_r.prox_covered <= in_prox_covered;
    end
  end

  dtw_core #(
    .X_LIMIT(X_LIMIT),
    .Y_LIMIT(Y_LIMIT)
  ) u_core (
    .cfg       (cfg_r),
    .item      (item_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .wake      (wake_nxt)
  );

  // detector state and result register move together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StateReset;
      out_valid_r <= 1'b0;
    end else if (process) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (advance) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_wake_r <= wake_nxt;
      out_held_r <= state_nxt.tap_count;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_wake           = out_wake_r;
  assign out_first_tap_held = out_held_r;

  // a wake always drops the stored tap
  a_wake_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_wake_r |-> !out_held_r)
    else $error("wake reported with a tap still held");

  // a processed event always produces a result
  a_process_result: assert property (@(posedge clk) disable iff (!rst_n)
    process |=> out_valid_r)
    else $error("processed transaction produced no result");

  // disabled detector leaves state untouched
  a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
    process && !cfg_r.enable |=> $stable(state_r))
    else $error("state changed while detection disabled");

  // stall only when the input register is occupied
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid_r && out_valid_r)
    else $error("input stalled with nothing held");

  // wake only from an armed tap store
  a_wake_needs_tap: assert property (@(posedge clk) disable iff (!rst_n)
    process && wake_nxt |-> state_r.tap_count)
    else $error("wake without a stored first tap");

endmodule

>>> tb/sv/double_tap_wake_detector_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for double_tap_wake_detector_unit: directed and random touch events.
// Depends on dtw_pkg and the detector RTL; the expected results come from a local predictor.
module double_tap_wake_detector_unit_tb;
  import dtw_pkg::*;

  // Event kinds with no package name: modes 5 to 7 change no captured value
  localparam logic [2:0] MODE_OTHER  = 3'd5;
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int QuietLimit   = 2000;  // cycles with no transaction before giving up
  localparam int ItemsPerPhase = 100;

  typedef struct {
    logic wake;
    logic held;
  } wake_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_ENABLE;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_mode = MODE_SLOT;
  logic signed [15:0] in_event_value = 16'sd0;
  logic [31:0] in_now_ticks = 32'd0;
  logic        in_screen_on = 1'b0;
  logic        in_prox_covered = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_wake;
  logic        out_first_tap_held;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_tap_wake_detector_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_event_value    (in_event_value),
    .in_now_ticks      (in_now_ticks),
    .in_screen_on      (in_screen_on),
    .in_prox_covered   (in_prox_covered),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_wake          (out_wake),
    .out_first_tap_held(out_first_tap_held)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  dtw_item_t    pending_events[$];    // events waiting to be driven
  wake_result_t expected_results[$];  // one per accepted event, oldest first
  int           mismatches = 0;
  int           items_queued = 0;
  int           send_idle_pct = 0;    // chance per new transaction of a sender gap
  int           hold_pct = 0;         // chance per cycle of stalling the result side
  bit           in_took = 1'b0;       // input transaction accepted at the last rising edge
  int           quiet_cycles = 0;

  // Predictor copy of the registers
  logic        det_en = 1'b0;
  logic [11:0] det_feather = FeatherReset;
  logic [15:0] det_window = WindowReset;

  // Predictor copy of the detector state
  logic        pressed = 1'b0;
  logic        x_got = 1'b0;
  logic        y_got = 1'b0;
  logic        lift_armed = 1'b1;
  logic [15:0] pt_x = 16'd0;
  logic [15:0] pt_y = 16'd0;
  logic        have_first = 1'b0;
  logic [15:0] first_x = 16'd0;
  logic [15:0] first_y = 16'd0;
  logic [31:0] first_t = 32'd0;

  // Stimulus generator state
  logic [31:0] tick_now = 32'd0;
  int          anchor_x = 800;
  int          anchor_y = 1200;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void forget_taps();
    have_first = 1'b0;
    first_t    = 32'd0;
    first_x    = 16'd0;
    first_y    = 16'd0;
    pt_x       = 16'd0;
    pt_y       = 16'd0;
    lift_armed = 1'b0;
  endfunction

  function automatic void keep_first_tap(input logic [15:0] xr, input logic [15:0] yr,
                                         input logic [31:0] now);
    have_first = 1'b1;
    first_t    = now;
    first_x    = xr;
    first_y    = yr;
  endfunction

  // Judge one completed tap; returns the wake pulse
  function automatic logic judge_tap(input logic [15:0] xr, input logic [15:0] yr,
                                     input logic [31:0] now, input logic prox);
    int          x, y, dx, dy;
    logic [31:0] elapsed;
    x = int'($signed(xr));
    y = int'($signed(yr));
    if (prox) return 1'b0;
    // off-screen taps are dropped and the stored tap survives
    if (x < 0 || x > int'(XLimitDefault) || y < 0 || y > int'(YLimitDefault)) return 1'b0;
    if (!have_first) begin
      keep_first_tap(xr, yr, now);
      return 1'b0;
    end
    dx = x - int'($signed(first_x));
    dy = y - int'($signed(first_y));
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    elapsed = now - first_t;  // wraps modulo 2^32
    if (dx < int'(det_feather) && dy < int'(det_feather) && elapsed < {16'd0, det_window}) begin
      forget_taps();
      return 1'b1;
    end
    forget_taps();
    keep_first_tap(xr, yr, now);
    return 1'b0;
  endfunction

  function automatic void predict_wake(input dtw_item_t ev, output wake_result_t res);
    logic signed [15:0] v;
    logic               is_release;
    v          = ev.event_value;
    is_release = (ev.mode == MODE_TRACK_ID) && (v == -16'sd1);
    res.wake   = 1'b0;
    if (!ev.screen_on && det_en) begin
      if (ev.mode == MODE_SLOT && v > 16'sd0) begin
        // second finger: drop the stored tap, keep the capture flags
        if (pressed) forget_taps();
      end else if (!(is_release && !(x_got && y_got))) begin
        if (is_release) lift_armed = 1'b1;
        if (ev.mode == MODE_BUTTON && v == 16'sd1) pressed = 1'b1;
        if (ev.mode == MODE_BUTTON && v == 16'sd0) pressed = 1'b0;
        if (ev.mode == MODE_X && pressed && !x_got) begin
          pt_x  = v;
          x_got = 1'b1;
        end
        if (ev.mode == MODE_Y && pressed && !y_got) begin
          pt_y  = v;
          y_got = 1'b1;
        end
        if (x_got && y_got && lift_armed && !pressed) begin
          lift_armed = 1'b0;
          x_got      = 1'b0;
          y_got      = 1'b0;
          res.wake   = judge_tap(pt_x, pt_y, ev.now_ticks, ev.prox_covered);
        end
      end
    end
    res.held = have_first;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. A stalled transaction holds;
  // a new one is launched only once the previous one was taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_events
    dtw_item_t ev;
    out_stall <= rst_n && ($urandom_range(99) < hold_pct);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        ev = pending_events.pop_front();
        in_mode         <= ev.mode;
        in_event_value  <= ev.event_value;
        in_now_ticks    <= ev.now_ticks;
        in_screen_on    <= ev.screen_on;
        in_prox_covered <= ev.prox_covered;
        in_valid        <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge, predicts on input
  // transactions and checks result transactions against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    dtw_item_t    ev;
    wake_result_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        ev.mode         = in_mode;
        ev.event_value  = in_event_value;
        ev.now_ticks    = in_now_ticks;
        ev.screen_on    = in_screen_on;
        ev.prox_covered = in_prox_covered;
        predict_wake(ev, want);
        expected_results.push_back(want);
        in_took = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_wake !== want.wake)
            report_mismatch($sformatf("wake got %b want %b", out_wake, want.wake));
          if (out_first_tap_held !== want.held)
            report_mismatch($sformatf("first_tap_held got %b want %b",
                                      out_first_tap_held, want.held));
        end
      end
    end
  end

  // Watchdog: too long without any transaction ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_event(input logic [2:0] m, input int v, input bit scr, input bit prox);
    dtw_item_t e;
    e.mode         = m;
    e.event_value  = v[15:0];
    e.now_ticks    = tick_now;
    e.screen_on    = scr;
    e.prox_covered = prox;
    pending_events.push_back(e);
    items_queued++;
    tick_now += $urandom_range(2);
  endtask

  // One finger tap; with noise, odd events may arrive with the screen on
  task automatic queue_tap(input int x, input int y, input bit prox, input bit noisy);
    queue_event(MODE_TRACK_ID, $urandom_range(32767), noisy && $urandom_range(39) == 0, prox);
    queue_event(MODE_BUTTON, 1, noisy && $urandom_range(39) == 0, prox);
    queue_event(MODE_X, x, noisy && $urandom_range(39) == 0, prox);
    queue_event(MODE_Y, y, noisy && $urandom_range(39) == 0, prox);
    if (noisy && $urandom_range(3) == 0)
      queue_event(MODE_X, $urandom_range(XLimitDefault), 1'b0, prox);  // ignored repeat
    queue_event(MODE_TRACK_ID, -1, noisy && $urandom_range(39) == 0, prox);
    queue_event(MODE_BUTTON, 0, noisy && $urandom_range(39) == 0, prox);
  endtask

  // Mostly well-formed taps, often near the last one; the rest second fingers,
  // broken sequences and raw noise
  task automatic queue_random_burst();
    int r, x, y, reach, m, v;
    r     = $urandom_range(99);
    reach = int'(det_feather) + 40;
    if (r < 70) begin
      if ($urandom_range(1) == 0) begin
        anchor_x = $urandom_range(XLimitDefault);
        anchor_y = $urandom_range(YLimitDefault);
      end
      x = anchor_x + int'($urandom_range(2 * reach)) - reach;
      y = anchor_y + int'($urandom_range(2 * reach)) - reach;
      if ($urandom_range(11) == 0) x = $urandom_range(65535);
      if ($urandom_range(11) == 0) y = $urandom_range(65535);
      tick_now += $urandom_range(2 * int'(det_window) + 8);
      if ($urandom_range(49) == 0) tick_now += $urandom;  // far jump, may wrap
      queue_tap(x, y, $urandom_range(15) == 0, 1'b1);
    end else if (r < 80) begin
      queue_event(MODE_BUTTON, 1, 1'b0, 1'b0);
      queue_event(MODE_X, $urandom_range(XLimitDefault), 1'b0, 1'b0);
      queue_event(MODE_SLOT, $urandom_range(32767, 1), 1'b0, 1'b0);
      queue_event(MODE_Y, $urandom_range(YLimitDefault), 1'b0, 1'b0);
      queue_event(MODE_TRACK_ID, -1, 1'b0, 1'b0);
      queue_event(MODE_BUTTON, 0, 1'b0, 1'b0);
    end else if (r < 90) begin
      repeat ($urandom_range(4, 1)) begin
        m = $urandom_range(4);
        case (m)
          MODE_SLOT:     v = $urandom_range(3);
          MODE_TRACK_ID: v = $urandom_range(1) ? -1 : int'($urandom_range(100));
          MODE_BUTTON:   v = $urandom_range(1);
          MODE_X:        v = $urandom_range(XLimitDefault);
          default:       v = $urandom_range(YLimitDefault);
        endcase
        queue_event(m[2:0], v, 1'b0, 1'($urandom_range(1)));
      end
    end else begin
      queue_event(3'($urandom_range(7)), int'($urandom_range(65535)) - 32768,
                  1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLE:  det_en      = val[0];
      CFG_FEATHER: det_feather = val[11:0];
      CFG_WINDOW:  det_window  = val[15:0];
      default:     ;
    endcase
  endtask

  // Block idle: nothing to send, nothing in flight, nothing owed
  task automatic wait_drained();
    while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic fill_random(input int count);
    int start;
    start = items_queued;
    while (items_queued - start < count) queue_random_burst();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Detection off after reset: both events are ignored
    queue_event(MODE_BUTTON, 1, 1'b0, 1'b0);
    queue_event(MODE_X, 32767, 1'b1, 1'b1);
    wait_drained();
    write_reg(CFG_ENABLE, 1);
    @(posedge clk);

    // Two close taps across the tick wrap give a wake; x difference one under the limit
    tick_now = 32'hFFFF_FFF8;
    queue_tap(0, 0, 1'b0, 1'b0);
    queue_tap(149, 149, 1'b0, 1'b0);
    // release with nothing captured, an unknown mode, an event with the screen on
    queue_event(MODE_TRACK_ID, -1, 1'b0, 1'b0);
    queue_event(MODE_UNUSED, -32768, 1'b0, 1'b0);
    queue_event(MODE_BUTTON, 1, 1'b1, 1'b0);
    // off-screen tap, then a second finger while pressed
    queue_tap(-32768, int'(YLimitDefault), 1'b0, 1'b0);
    queue_event(MODE_BUTTON, 1, 1'b0, 1'b0);
    queue_event(MODE_SLOT, 32767, 1'b0, 1'b0);
    queue_event(MODE_OTHER, 0, 1'b0, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          send_idle_pct = 0;
          hold_pct      = 0;
          write_reg(CFG_FEATHER, 32'(FeatherReset));
          write_reg(CFG_WINDOW, 32'(WindowReset));
          @(posedge clk);
          fill_random(ItemsPerPhase);
        end
        1: begin
          send_idle_pct = 47;
          hold_pct      = 0;
          write_reg(CFG_FEATHER, 4095);
          write_reg(CFG_WINDOW, 65535);
          @(posedge clk);
          fill_random(ItemsPerPhase);
        end
        2: begin
          send_idle_pct = 0;
          hold_pct      = 47;
          // detection off for a short burst
          write_reg(CFG_ENABLE, 0);
          @(posedge clk);
          fill_random(10);
          wait_drained();
          write_reg(CFG_ENABLE, 1);
          write_reg(CFG_FEATHER, 0);
          write_reg(CFG_WINDOW, 0);
          @(posedge clk);
          fill_random(30);
          wait_drained();
          write_reg(CFG_FEATHER, $urandom_range(400, 20));
          write_reg(CFG_WINDOW, $urandom_range(200, 10));
          @(posedge clk);
          fill_random(ItemsPerPhase - 40);
        end
        default: begin
          send_idle_pct = 16;
          hold_pct      = 16;
          write_reg(CFG_FEATHER, $urandom_range(600, 20));
          write_reg(CFG_WINDOW, $urandom_range(300, 10));
          @(posedge clk);
          fill_random(ItemsPerPhase);
        end
      endcase
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
